### src/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg: shared types for the sliding median filter
// Sample type, the link bundle passed between neighboring sort cells,
// and the boundary links at both ends of the cell row.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int SLOT_W   = 5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SLOT_W-1:0]          slot_t;

    typedef struct packed {
        sample_t value;
        slot_t   slot;
        logic    le;
    } smf_link_t;

    // below the lowest cell: an element that is always <= the new sample
    localparam smf_link_t LINK_BOTTOM = '{value: '0, slot: '0, le: 1'b1};
    // above the highest cell: an element that is never <= the new sample
    localparam smf_link_t LINK_TOP    = '{value: '0, slot: '0, le: 1'b0};

endpackage

### src/smf_cell.sv
// ----------------------------------------------------------------------------
// smf_cell: one cell of the sorted sample row
// Holds one sample and its ring slot. A push drops the entry at the write
// pointer and inserts the new sample in sorted place; a clear zeroes values.
// ----------------------------------------------------------------------------
module smf_cell
    import smf_pkg::*;
#(
    parameter int RESET_SLOT = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      update,
    input  logic      clear_window,
    input  sample_t   sample,
    input  slot_t     write_slot,
    input  smf_link_t lower,
    input  smf_link_t upper,
    input  logic      above_in,
    output smf_link_t link,
    output logic      above_out
);

    sample_t value_reg;
    sample_t value_next;
    slot_t   slot_reg;
    slot_t   slot_next;
    logic    del;
    logic    le_self;
    logic    le_prev_c;
    logic    le_self_c;
    logic    take_sample;

    assign le_self   = ($signed(value_reg) <= $signed(sample));
    assign del       = (slot_reg == write_slot);
    assign above_out = above_in | del;

    assign link.value = value_reg;
    assign link.slot  = slot_reg;
    assign link.le    = le_self;

    // compare flags of the row with the dropped entry squeezed out
    assign le_prev_c   = above_in  ? le_self  : lower.le;
    assign le_self_c   = above_out ? upper.le : le_self;
    assign take_sample = le_prev_c & ~le_self_c;

    always_comb begin
        value_next = value_reg;
        slot_next  = slot_reg;
        if (clear_window) begin
            value_next = '0;
        end else if (le_self_c) begin
            value_next = above_out ? upper.value : value_reg;
            slot_next  = above_out ? upper.slot  : slot_reg;
        end else if (take_sample) begin
            value_next = sample;
            slot_next  = write_slot;
        end else begin
            value_next = above_in ? value_reg : lower.value;
            slot_next  = above_in ? slot_reg  : lower.slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            slot_reg  <= SLOT_W'(RESET_SLOT);
        end else if (update) begin
            value_reg <= value_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

### src/sliding_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_filter: running median over a window of altitude samples
// Input channel s_*: s_clear_window zeroes the window, else s_sample
// (signed, 8 fraction bits) replaces the oldest window entry.
// Result channel m_*: one m_median per input transaction, the element at
// sorted index WINDOW/2 of the window after the update.
// The window is a row of WINDOW cells kept in ascending order; each
// transaction that is not a clear drops the oldest entry and inserts the
// new sample, so the median sits in a fixed cell.
// Latency: the result is valid the cycle after the input transaction.
// Throughput: one transaction per cycle while m_ready is high.
// Stall: while a result waits with m_ready low, s_ready is low and the
// window holds; nothing is lost or repeated.
// Reset: the window is all zero, the write pointer is zero and no result
// is pending. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module sliding_median_filter
    import smf_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    s_clear_window,
    input  sample_t s_sample,
    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_median
);

    smf_link_t links [WINDOW];
    logic      above [WINDOW+1];
    slot_t     wp_reg;
    slot_t     wp_next;
    logic      m_valid_reg;
    logic      m_valid_next;
    logic      accept;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign above[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++) begin : g_cell
            smf_link_t lower_link;
            smf_link_t upper_link;
            if (i == 0) begin : g_lo_end
                assign lower_link = LINK_BOTTOM;
            end else begin : g_lo
                assign lower_link = links[i-1];
            end
            if (i == WINDOW - 1) begin : g_hi_end
                assign upper_link = LINK_TOP;
            end else begin : g_hi
                assign upper_link = links[i+1];
            end
            smf_cell #(
                .RESET_SLOT(i)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .update       (accept),
                .clear_window (s_clear_window),
                .sample       (s_sample),
                .write_slot   (wp_reg),
                .lower        (lower_link),
                .upper        (upper_link),
                .above_in     (above[i]),
                .link         (links[i]),
                .above_out    (above[i+1])
            );
        end
    endgenerate

    always_comb begin
        wp_next = wp_reg;
        if (accept && !s_clear_window) begin
            wp_next = (wp_reg == SLOT_W'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_median = links[WINDOW/2].value;

endmodule

### src/smf_checker.sv
// ----------------------------------------------------------------------------
// smf_checker: port-level checks for the sliding median filter
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
module smf_checker
    import smf_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    s_clear_window,
    input sample_t s_sample,
    input logic    m_valid,
    input logic    m_ready,
    input sample_t m_median
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_median))
        else $error("stalled result changed");

    // every input transaction gives a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("missing result after input transaction");

    // a clear gives a zero median
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_clear_window |=> m_median == '0)
        else $error("median not zero after clear");

    // no input taken while a result is stuck
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    // reset leaves no pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind sliding_median_filter smf_checker u_smf_checker (.*);

### tb/sliding_median_filter_test.sv
// ----------------------------------------------------------------------------
// sliding_median_filter_test: self-checking bench for the sliding median filter
// A short table of directed transactions covers the sample extremes, pointer
// wrap, clears, a fresh window and ties. Random transactions follow in
// phases with different sender and receiver idling. Every accepted input
// updates a mirror of the window, which predicts the median that the result
// channel must return in order.
// ----------------------------------------------------------------------------
module sliding_median_filter_test;
    import smf_pkg::*;

    localparam int      WINDOW       = 5;
    localparam int      RESET_CYCLES = 4;
    localparam int      DRAIN_CYCLES = 10;
    localparam int      CYCLE_LIMIT  = 400000;
    localparam int      PRINT_LIMIT  = 100;
    localparam int      DIR_ROWS     = 22;
    localparam logic    OP_PUSH      = 1'b0;
    localparam logic    OP_CLEAR     = 1'b1;
    localparam sample_t SAMPLE_MAX   = 24'sh7fffff;
    localparam sample_t SAMPLE_MIN   = 24'sh800000;
    localparam sample_t SAMPLE_ZERO  = 24'sd0;

    typedef struct packed {
        logic    op;
        sample_t smp;
        logic    typed;
        sample_t want;
    } dir_row_t;

    // typed rows carry the median read straight off the window contents
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{OP_PUSH,  SAMPLE_MAX,    1'b1, SAMPLE_ZERO},
        '{OP_PUSH,  SAMPLE_MIN,    1'b1, SAMPLE_ZERO},
        '{OP_PUSH,  SAMPLE_MAX,    1'b1, SAMPLE_ZERO},
        '{OP_PUSH,  SAMPLE_MAX,    1'b1, SAMPLE_MAX},
        '{OP_PUSH,  24'sd1,        1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  SAMPLE_MIN,    1'b0, SAMPLE_ZERO},
        '{OP_CLEAR, SAMPLE_MAX,    1'b1, SAMPLE_ZERO},
        '{OP_PUSH,  -24'sd1,       1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  24'sd256,      1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  24'sd256,      1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  24'sd256,      1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  -24'sd256,     1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  24'sh555555,   1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  24'shaaaaaa,   1'b0, SAMPLE_ZERO},
        '{OP_CLEAR, 24'sh555555,   1'b1, SAMPLE_ZERO},
        '{OP_CLEAR, SAMPLE_ZERO,   1'b1, SAMPLE_ZERO},
        '{OP_PUSH,  24'sd7,        1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  24'sd7,        1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  24'sd7,        1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  24'sd7,        1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  24'sd7,        1'b0, SAMPLE_ZERO},
        '{OP_PUSH,  SAMPLE_ZERO,   1'b0, SAMPLE_ZERO}
    };

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    logic    s_clear_window;
    sample_t s_sample;
    logic    m_valid;
    logic    m_ready;
    sample_t m_median;

    sample_t window_mirror [WINDOW];
    int      wr_ptr_mirror;
    sample_t median_q [$];
    sample_t median_want;
    sample_t last_sample;
    int      error_count;
    int      cycle_count;
    int      src_idle_pct;
    int      sink_stall_pct;
    int      sink_hold_cycles;

    sliding_median_filter #(
        .WINDOW(WINDOW)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_clear_window (s_clear_window),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median       (m_median)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_clear_window   = OP_PUSH;
        s_sample         = SAMPLE_ZERO;
        m_ready          = 1'b0;
        wr_ptr_mirror    = 0;
        last_sample      = SAMPLE_ZERO;
        error_count      = 0;
        cycle_count      = 0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 0;
        for (int i = 0; i < WINDOW; i++) begin
            window_mirror[i] = SAMPLE_ZERO;
        end
    end

    task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        error_count++;
    endtask

    // apply one transaction to the window mirror and return the new median
    function automatic sample_t update_window(input logic op, input sample_t smp);
        sample_t sorted [WINDOW];
        sample_t key;
        int      i;
        int      j;
        if (op == OP_CLEAR) begin
            for (i = 0; i < WINDOW; i++) begin
                window_mirror[i] = SAMPLE_ZERO;
            end
        end else begin
            window_mirror[wr_ptr_mirror] = smp;
            wr_ptr_mirror = (wr_ptr_mirror + 1 >= WINDOW) ? 0 : wr_ptr_mirror + 1;
        end
        for (i = 0; i < WINDOW; i++) begin
            sorted[i] = window_mirror[i];
        end
        for (i = 1; i < WINDOW; i++) begin
            key = sorted[i];
            j   = i - 1;
            while (j >= 0 && sorted[j] > key) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        return sorted[WINDOW / 2];
    endfunction

    task automatic send_item(input logic op, input sample_t smp, input logic typed,
                             input sample_t want);
        sample_t pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_clear_window <= op;
        s_sample       <= smp;
        @(negedge aclk);
        while (!s_ready) begin
            @(negedge aclk);
        end
        pred = update_window(op, smp);
        median_q.push_back(typed ? want : pred);
        @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        logic    op;
        sample_t smp;
        int      pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            op   = (pick == 0) ? OP_CLEAR : OP_PUSH;
            if (pick < 8) begin
                smp = sample_t'($urandom);
            end else if (pick < 14) begin
                // narrow range so the window sees many ties
                smp = sample_t'(int'($urandom_range(0, 6)) - 3);
            end else if (pick < 16) begin
                smp = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            end else begin
                smp = last_sample + sample_t'(int'($urandom_range(0, 512)) - 256);
            end
            last_sample = smp;
            send_item(op, smp, 1'b0, SAMPLE_ZERO);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (median_q.size() != 0);
    endtask

    always @(posedge aclk) begin
        if (sink_hold_cycles > 0) begin
            sink_hold_cycles = sink_hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // outputs settle after the rising edge, so the falling edge sees the handshake
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (median_q.size() == 0) begin
                report_mismatch("result with no transaction pending", m_median, SAMPLE_ZERO);
            end else begin
                median_want = median_q.pop_front();
                if (m_median !== median_want) begin
                    report_mismatch("median", m_median, median_want);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sliding_median_filter regression: fail");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(dir_rows[r].op, dir_rows[r].smp, dir_rows[r].typed, dir_rows[r].want);
        end
        send_random(450);

        // receiver holds off while the sender keeps offering transactions
        sink_hold_cycles = 300;
        send_random(100);
        wait_idle();

        src_idle_pct   = 86;
        sink_stall_pct = 0;
        send_random(400);

        src_idle_pct   = 0;
        sink_stall_pct = 86;
        send_random(400);

        src_idle_pct   = 8;
        sink_stall_pct = 8;
        send_random(450);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_random(150);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("sliding_median_filter regression: pass");
        end else begin
            $display("sliding_median_filter regression: fail");
        end
        $finish;
    end

endmodule
